@@ rtl/pwc_pkg.sv @@
// shared types, constants and helpers for the four-channel pulse width capture
package pwc_pkg;

  localparam int unsigned NumCh    = 4;
  localparam int unsigned MaskBits = 4;
  localparam int unsigned ChW      = 2;
  localparam int unsigned TimeBits = 32;

  localparam logic [NumCh-1:0] AllMarks = '1;

  typedef logic [TimeBits-1:0] time_t;

  typedef struct packed {
    logic [MaskBits-1:0] rise_mask;
    logic [MaskBits-1:0] fall_mask;
    time_t               timestamp;
  } event_t;

  typedef struct packed {
    logic                  width_valid;
    logic [ChW-1:0]        channel;
    time_t                 width;
    logic                  frame_done;
    logic [NumCh-1:0][TimeBits-1:0] ch_width;
  } result_t;

  typedef struct packed {
    logic           hit;
    logic [ChW-1:0] idx;
  } pick_t;

  // lowest set bit of an edge mask that maps to a real channel
  function automatic pick_t lowest_ch(input logic [MaskBits-1:0] mask);
    pick_t p;
    p = '0;
    for (int i = NumCh - 1; i >= 0; i--) begin
      if (i < int'(MaskBits) && mask[i]) begin
        p.hit = 1'b1;
        p.idx = ChW'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/pwc_in_stage.sv @@
// input register stage holding one edge event request
module pwc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pwc_pkg::event_t ev_i,
  input  logic            take_i,
  output logic            valid_o,
  output pwc_pkg::event_t ev_o
);

  logic            valid_q, valid_d;
  pwc_pkg::event_t ev_q, ev_d;
  logic            load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    ev_d    = ev_q;
    if (load) begin
      valid_d = 1'b1;
      ev_d    = ev_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign valid_o = valid_q;
  assign ev_o    = ev_q;

endmodule

@@ rtl/pwc_capture.sv @@
// per-channel rise times, widths and update marks, with the width calculation
module pwc_capture (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  pwc_pkg::event_t  ev_i,
  output pwc_pkg::result_t res_o
);

  logic [pwc_pkg::NumCh-1:0][pwc_pkg::TimeBits-1:0] rise_q, rise_d;
  logic [pwc_pkg::NumCh-1:0][pwc_pkg::TimeBits-1:0] widths_q, widths_d;
  logic [pwc_pkg::NumCh-1:0]                        flags_q, flags_d;
  pwc_pkg::pick_t                                   rp, fp;
  pwc_pkg::time_t                                   rise_sel;
  pwc_pkg::result_t                                 res;

  always_comb begin
    rp       = pwc_pkg::lowest_ch(ev_i.rise_mask);
    fp       = pwc_pkg::lowest_ch(ev_i.fall_mask);
    rise_d   = rise_q;
    widths_d = widths_q;
    flags_d  = flags_q;
    res      = '0;
    // rise handled first, so a same-channel fall sees the new rise time
    if (rp.hit) begin
      rise_d[rp.idx] = ev_i.timestamp;
    end
    rise_sel = rise_d[fp.idx];
    if (fp.hit && (ev_i.timestamp > rise_sel)) begin
      res.width_valid   = 1'b1;
      res.channel       = fp.idx;
      res.width         = ev_i.timestamp - rise_sel;
      widths_d[fp.idx]  = ev_i.timestamp - rise_sel;
      flags_d[fp.idx]   = 1'b1;
      if (flags_d == pwc_pkg::AllMarks) begin
        res.frame_done = 1'b1;
        flags_d        = '0;
      end
    end
    res.ch_width = widths_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q   <= '0;
      widths_q <= '0;
      flags_q  <= '0;
    end else if (fire_i) begin
      rise_q   <= rise_d;
      widths_q <= widths_d;
      flags_q  <= flags_d;
    end
  end

  assign res_o = res;

  a_done_needs_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.frame_done |-> res.width_valid)
    else $error("frame flagged without a measured width");

  a_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.width_valid |-> res.width != '0)
    else $error("measured width is zero");

  a_marks_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q != pwc_pkg::AllMarks)
    else $error("update marks left full");

  a_marks_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.frame_done |=> flags_q == '0)
    else $error("update marks not cleared after frame");

endmodule

@@ rtl/pwc_out_stage.sv @@
// result register feeding the output channel
module pwc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pwc_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             free_o,
  output pwc_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  pwc_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/four_channel_pulse_width_capture.sv @@
// top level of the four-channel pulse width capture
//
//  channel  handshake                 payload
//  input    in_valid_i / in_ready_o   rise_mask_i, fall_mask_i, timestamp_i
//  output   out_valid_o / out_ready_i width_valid_o, channel_o, width_o, frame_done_o,
//                                     width_ch0_o .. width_ch3_o
//
// one request a cycle while the output is not stalled; a request's result passes through
// the input register, then the capture logic into the result register
// reset clears rise times, widths and update marks to zero
// a stalled output holds the result register, then the input register, then in_ready_o
module four_channel_pulse_width_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  rise_mask_i,
  input  logic [3:0]  fall_mask_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        width_valid_o,
  output logic [1:0]  channel_o,
  output logic [31:0] width_o,
  output logic        frame_done_o,
  output logic [31:0] width_ch0_o,
  output logic [31:0] width_ch1_o,
  output logic [31:0] width_ch2_o,
  output logic [31:0] width_ch3_o
);

  pwc_pkg::event_t  ev_in, ev_s1;
  pwc_pkg::result_t res_d, res_q;
  logic             s1_valid;
  logic             out_free;
  logic             fire;

  assign ev_in.rise_mask = rise_mask_i;
  assign ev_in.fall_mask = fall_mask_i;
  assign ev_in.timestamp = timestamp_i;

  assign fire = s1_valid && out_free;

  pwc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ev_i       (ev_in),
    .take_i     (fire),
    .valid_o    (s1_valid),
    .ev_o       (ev_s1)
  );

  pwc_capture u_cap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .ev_i   (ev_s1),
    .res_o  (res_d)
  );

  pwc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_q)
  );

  assign width_valid_o = res_q.width_valid;
  assign channel_o     = res_q.channel;
  assign width_o       = res_q.width;
  assign frame_done_o  = res_q.frame_done;
  assign width_ch0_o   = res_q.ch_width[0];
  assign width_ch1_o   = res_q.ch_width[1];
  assign width_ch2_o   = res_q.ch_width[2];
  assign width_ch3_o   = res_q.ch_width[3];

endmodule

@@ tb/sv/tb_four_channel_pulse_width_capture.sv @@
// self-checking testbench for the four-channel pulse width capture, with a predictor and scoreboard
module tb_four_channel_pulse_width_capture;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;
  localparam int RandomEvents  = 1250;

  typedef logic [pwc_pkg::MaskBits-1:0] mask_t;

  typedef struct packed {
    logic                                             width_valid;
    logic [pwc_pkg::ChW-1:0]                          channel;
    pwc_pkg::time_t                                   width;
    logic                                             frame_done;
    logic [pwc_pkg::NumCh-1:0][pwc_pkg::TimeBits-1:0] ch_width;
  } capture_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  rise_mask_i;
  logic [3:0]  fall_mask_i;
  logic [31:0] timestamp_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        width_valid_o;
  logic [1:0]  channel_o;
  logic [31:0] width_o;
  logic        frame_done_o;
  logic [31:0] width_ch0_o;
  logic [31:0] width_ch1_o;
  logic [31:0] width_ch2_o;
  logic [31:0] width_ch3_o;

  four_channel_pulse_width_capture DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rise_mask_i  (rise_mask_i),
    .fall_mask_i  (fall_mask_i),
    .timestamp_i  (timestamp_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .width_valid_o(width_valid_o),
    .channel_o    (channel_o),
    .width_o      (width_o),
    .frame_done_o (frame_done_o),
    .width_ch0_o  (width_ch0_o),
    .width_ch1_o  (width_ch1_o),
    .width_ch2_o  (width_ch2_o),
    .width_ch3_o  (width_ch3_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  pwc_pkg::time_t            rise_at[pwc_pkg::NumCh]    = '{default: '0};
  pwc_pkg::time_t            fall_at[pwc_pkg::NumCh]    = '{default: '0};
  pwc_pkg::time_t            held_width[pwc_pkg::NumCh] = '{default: '0};
  logic [pwc_pkg::NumCh-1:0] fresh_marks                = '0;

  pwc_pkg::event_t pending_events[$];
  capture_t        expected_captures[$];
  int              mismatches  = 0;
  int              quiet_cycles = 0;
  int              calm_left   = 0;
  int              send_gap;
  int              hold_cnt;

  function automatic int first_edge_ch(mask_t mask);
    for (int i = 0; i < int'(pwc_pkg::NumCh); i++) begin
      if (mask[i]) return i;
    end
    return -1;
  endfunction

  // rise is applied before fall, so both on one channel leave no width
  function automatic capture_t predict_capture(pwc_pkg::event_t ev);
    capture_t c;
    int       rch;
    int       fch;
    c   = '0;
    rch = first_edge_ch(ev.rise_mask);
    fch = first_edge_ch(ev.fall_mask);
    if (rch >= 0) rise_at[rch] = ev.timestamp;
    if (fch >= 0) begin
      fall_at[fch] = ev.timestamp;
      if (fall_at[fch] > rise_at[fch]) begin
        c.width_valid     = 1'b1;
        c.channel         = fch[pwc_pkg::ChW-1:0];
        c.width           = fall_at[fch] - rise_at[fch];
        held_width[fch]   = c.width;
        fresh_marks[fch]  = 1'b1;
        if (fresh_marks == pwc_pkg::AllMarks) begin
          c.frame_done = 1'b1;
          fresh_marks  = '0;
        end
      end
    end
    for (int i = 0; i < int'(pwc_pkg::NumCh); i++) c.ch_width[i] = held_width[i];
    return c;
  endfunction

  // mostly back to back or short gaps, a few long ones, and now and then a calm run
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 4) begin
      calm_left = $urandom_range(40, 160);
      return 0;
    end
    if (r < 450) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 970) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // edge mask whose lowest set bit is ch, with junk above it
  function automatic mask_t edge_mask(int ch);
    mask_t m;
    m = mask_t'($urandom) << (ch + 1);
    return m | (mask_t'(1) << ch);
  endfunction

  task automatic push_event(logic [3:0] rise, logic [3:0] fall, pwc_pkg::time_t stamp);
    pwc_pkg::event_t ev;
    ev.rise_mask = rise;
    ev.fall_mask = fall;
    ev.timestamp = stamp;
    pending_events.push_back(ev);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_events
    pwc_pkg::event_t next_ev;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_captures.push_back(
          predict_capture(pwc_pkg::event_t'({rise_mask_i, fall_mask_i, timestamp_i})));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_events.size() != 0) begin
          next_ev     = pending_events.pop_front();
          rise_mask_i <= next_ev.rise_mask;
          fall_mask_i <= next_ev.fall_mask;
          timestamp_i <= next_ev.timestamp;
          in_valid_i  <= 1'b1;
          send_gap    <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i) begin : watch_results
    capture_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_captures.size() == 0) begin
          $error("result with no request outstanding: channel %0d width %0h",
                 channel_o, width_o);
          mismatches++;
        end else begin
          want = expected_captures.pop_front();
          check_field("width_valid", 32'(want.width_valid), 32'(width_valid_o));
          check_field("channel", 32'(want.channel), 32'(channel_o));
          check_field("width", want.width, width_o);
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done_o));
          check_field("width_ch0", want.ch_width[0], width_ch0_o);
          check_field("width_ch1", want.ch_width[1], width_ch1_o);
          check_field("width_ch2", want.ch_width[2], width_ch2_o);
          check_field("width_ch3", want.ch_width[3], width_ch3_o);
        end
      end
      if (hold_cnt != 0) begin
        out_ready_i <= 1'b0;
        hold_cnt    <= hold_cnt - 1;
      end else begin
        out_ready_i <= 1'b1;
        hold_cnt    <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    pwc_pkg::time_t stamp;
    pwc_pkg::time_t w;
    int             start;
    int             ch;
    int             r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    rise_mask_i = '0;
    fall_mask_i = '0;
    timestamp_i = '0;

    // directed: extremes, same-item rise and fall, fall not after rise, multi-bit masks
    push_event(4'h0, 4'h0, 32'h0000_0000);
    push_event(4'h0, 4'h1, 32'h0000_0005);
    push_event(4'h1, 4'h1, 32'h0000_0064);
    push_event(4'hF, 4'h0, 32'h0000_0010);
    push_event(4'h0, 4'hF, 32'hFFFF_FFFF);
    push_event(4'h2, 4'h0, 32'h0000_0000);
    push_event(4'h0, 4'h2, 32'hFFFF_FFFF);
    push_event(4'h4, 4'h0, 32'h8000_0000);
    push_event(4'h0, 4'h4, 32'h7FFF_FFFF);
    push_event(4'h0, 4'hC, 32'h8000_0001);
    push_event(4'h8, 4'h0, 32'h1234_5678);
    push_event(4'h0, 4'h8, 32'h1234_5678 + 32'd1500);
    push_event(4'h6, 4'h1, 32'd1000);
    push_event(4'hA, 4'hA, 32'd2000);
    push_event(4'h0, 4'h0, 32'hFFFF_FFFF);
    push_event(4'h3, 4'h2, 32'd3000);
    push_event(4'h8, 4'h0, 32'h5555_5555);
    push_event(4'h0, 4'h8, 32'hAAAA_AAAA);

    // random: mostly well-formed frames, some line noise
    stamp = $urandom;
    while (pending_events.size() < RandomEvents + 18) begin
      if ($urandom_range(0, 9) < 7) begin
        start = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          ch    = (start + k) % 4;
          stamp = stamp + pwc_pkg::time_t'($urandom_range(1, 400));
          push_event(edge_mask(ch),
                     ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0, stamp);
          if ($urandom_range(0, 19) == 0) continue;  // lost falling edge
          r = $urandom_range(0, 99);
          if (r < 80)      w = $urandom_range(900, 2100);
          else if (r < 95) w = $urandom_range(0, 20);
          else             w = $urandom;
          stamp = stamp + w;
          push_event(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0,
                     edge_mask(ch), stamp);
        end
      end else begin
        push_event(4'($urandom), 4'($urandom), $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_events.size() != 0 || in_valid_i || expected_captures.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_captures.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
